@@ hdl/modular_inverse_fermat_defines.svh @@
// ---------------------------------------------------------------------------
// Modular inverse assertion macros
// Concurrent assertion wrappers clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_FERMAT_DEFINES_SVH
`define MODULAR_INVERSE_FERMAT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MIF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modular_inverse_fermat: assertion failed");
// next-cycle implication
`define MIF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modular_inverse_fermat: assertion failed");
`else
`define MIF_ASSERT_IMP(lbl, ante, cons)
`define MIF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hdl/mif_pkg.sv @@
// ---------------------------------------------------------------------------
// Modular inverse package
// Modulus, exponent, Barrett constant and pipeline depths.
// ---------------------------------------------------------------------------
`default_nettype none

package mif_pkg;

  localparam int RES_W    = 30;
  localparam int EXP_BITS = 30;
  localparam int MUL_LAT  = 5;                   // stages per modular multiply
  localparam int CHAIN_LAT = EXP_BITS * MUL_LAT;

  typedef logic [RES_W-1:0] residue_t;

  localparam residue_t MODULUS  = 30'd1000000007;
  localparam residue_t EXPONENT = 30'd1000000005; // MODULUS - 2

  // floor(2^60 / MODULUS)
  localparam logic [30:0] BARRETT_MU = 31'd1152921496;

  localparam logic [31:0] MOD_X1 = {2'b00, MODULUS};
  localparam logic [31:0] MOD_X2 = {1'b0, MODULUS, 1'b0};

endpackage

`default_nettype wire

@@ hdl/mif_modmul.sv @@
// ---------------------------------------------------------------------------
// Pipelined modular multiplier
// a * b mod MODULUS by Barrett reduction, five register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module mif_modmul
  import mif_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     en,
  input  wire residue_t a,
  input  wire residue_t b,
  output residue_t      p
);

  logic [59:0] prod_r,  prod_nxt;
  logic [61:0] q2_r,    q2_nxt;
  logic [31:0] plo2_r;
  logic [31:0] plo3_r;
  logic [60:0] qp_full;
  logic [31:0] qp_r,    qp_nxt;
  logic [31:0] rem_r,   rem_nxt;
  logic [31:0] rem_m1,  rem_m2;
  residue_t    res_r,   res_nxt;

  // stage 1: full product
  assign prod_nxt = a * b;
  // stage 2: quotient estimate, q1 * mu
  assign q2_nxt   = prod_r[59:29] * BARRETT_MU;
  // stage 3: q3 * modulus, low word only (remainder < 3 * modulus < 2^32)
  assign qp_full  = q2_r[61:31] * MODULUS;
  assign qp_nxt   = qp_full[31:0];
  // stage 4: raw remainder
  assign rem_nxt  = plo3_r - qp_r;
  // stage 5: at most two corrections
  assign rem_m1   = rem_r - MOD_X1;
  assign rem_m2   = rem_r - MOD_X2;

  always_comb begin
    priority if (rem_r >= MOD_X2) begin
      res_nxt = rem_m2[RES_W-1:0];
    end else if (rem_r >= MOD_X1) begin
      res_nxt = rem_m1[RES_W-1:0];
    end else begin
      res_nxt = rem_r[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      q2_r   <= q2_nxt;
      plo2_r <= prod_r[31:0];
      qp_r   <= qp_nxt;
      plo3_r <= plo2_r;
      rem_r  <= rem_nxt;
      res_r  <= res_nxt;
    end
  end

  assign p = res_r;

endmodule

`default_nettype wire

@@ hdl/mif_chain.sv @@
// ---------------------------------------------------------------------------
// Square-and-multiply chain
// One step per exponent bit, LSB first; valid bits ride alongside.
// ---------------------------------------------------------------------------
`default_nettype none

module mif_chain
  import mif_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     in_valid,
  input  wire residue_t in_value,
  output logic          out_valid,
  output residue_t      out_value
);

  residue_t base [EXP_BITS];
  residue_t acc  [EXP_BITS+1];
  logic [CHAIN_LAT-1:0] vld_r;

  assign base[0] = in_value;
  assign acc[0]  = residue_t'(1);

  for (genvar i = 0; i < EXP_BITS; i++) begin : g_step
    if (EXPONENT[i]) begin : g_mul
      mif_modmul u_mul (
        .clk (clk),
        .en  (en),
        .a   (acc[i]),
        .b   (base[i]),
        .p   (acc[i+1])
      );
    end else begin : g_dly
      // bit clear: accumulator just keeps pace with the squarer
      residue_t dly_r [MUL_LAT];
      always_ff @(posedge clk) begin
        if (en) begin
          dly_r[0] <= acc[i];
          for (int k = 1; k < MUL_LAT; k++) begin
            dly_r[k] <= dly_r[k-1];
          end
        end
      end
      assign acc[i+1] = dly_r[MUL_LAT-1];
    end

    if (i < EXP_BITS - 1) begin : g_sqr
      mif_modmul u_sqr (
        .clk (clk),
        .en  (en),
        .a   (base[i]),
        .b   (base[i]),
        .p   (base[i+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[CHAIN_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[CHAIN_LAT-1];
  assign out_value = acc[EXP_BITS];

endmodule

`default_nettype wire

@@ hdl/modular_inverse_fermat.sv @@
// ---------------------------------------------------------------------------
// Modular inverse modulo 1000000007
// Returns value^(MODULUS-2) mod MODULUS, the Fermat inverse; 0 maps to 0.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel  in_valid / in_stall / in_value: one residue per transfer.
//     Values from MODULUS up to 2^30-1 are folded down by one subtraction.
//   Output channel out_valid / out_stall / out_inverse: one result per input,
//     in input order.
//   Pipeline from input transfer to out_valid: one input fold stage, 30
//     exponent steps of 5 stages each, one output register.
//   Throughput: one transfer per cycle while in_stall is low. Each exponent
//     step is a five-stage Barrett square (none in the last step) and a
//     multiply (bit set) or delay, so every stage holds a different item.
//   Stall: the output register holds while out_stall is high; the pipeline
//     keeps moving until one more finished result lands in a skid register,
//     then in_stall rises (it is a registered signal) and everything freezes.
//     Nothing is dropped or duplicated.
//   Reset: rst_n synchronous, active low; clears all valid bits, output and
//     skid. Data registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "modular_inverse_fermat_defines.svh"

module modular_inverse_fermat
  import mif_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire residue_t in_value,
  output logic          out_valid,
  input  wire logic     out_stall,
  output residue_t      out_inverse
);

  logic     adv;          // pipeline advance
  logic     out_take;     // output transfer this cycle
  logic     v0_r;
  residue_t x0_r;
  residue_t x0_nxt;
  logic     chain_v;
  residue_t chain_d;

  logic     out_v_r,  out_v_nxt;
  residue_t out_d_r,  out_d_nxt;
  logic     skid_v_r, skid_v_nxt;
  residue_t skid_d_r, skid_d_nxt;

  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;
  assign out_take = out_v_r && !out_stall;

  // input fold: 2^30 < 2*MODULUS, one subtraction is enough
  assign x0_nxt = (in_value >= MODULUS) ? (in_value - MODULUS) : in_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r <= x0_nxt;
    end
  end

  mif_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v0_r),
    .in_value  (x0_r),
    .out_valid (chain_v),
    .out_value (chain_d)
  );

  // output register plus skid
  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (adv) begin
      if (!out_v_r || out_take) begin
        out_v_nxt = chain_v;
        out_d_nxt = chain_d;
      end else if (chain_v) begin
        // output held: park the arriving result
        skid_v_nxt = 1'b1;
        skid_d_nxt = chain_d;
      end
    end else if (out_take) begin
      out_v_nxt  = 1'b1;
      out_d_nxt  = skid_d_r;
      skid_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid   = out_v_r;
  assign out_inverse = out_d_r;

  // skid only ever holds something behind a held output
  `MIF_ASSERT_IMP(a_skid_behind_out, skid_v_r, out_v_r)
  // a parked result stays put until the output drains
  `MIF_ASSERT_NXT(a_skid_holds, skid_v_r && !out_take, skid_v_r && $stable(skid_d_r))
  // a chain result arriving at a held output goes to the skid
  `MIF_ASSERT_NXT(a_skid_fill, adv && chain_v && out_v_r && out_stall, skid_v_r)
  // results are fully reduced
  `MIF_ASSERT_IMP(a_out_reduced, out_v_r, out_d_r < MODULUS)

endmodule

`default_nettype wire

@@ tb/sv/tb_modular_inverse_fermat.sv @@
// ---------------------------------------------------------------------------
// Modular inverse modulo 1000000007: self-checking testbench
// Sends residues through the valid/stall input channel, computes each
// expected inverse by square-and-multiply on 64-bit integers and checks the
// results in order, with random idle cycles on the sender and random stall
// cycles on the receiver.
// ---------------------------------------------------------------------------
module tb_modular_inverse_fermat
  import mif_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Slowest correct run: 1320 transfers, each held up by random idle cycles
  // on the sender and random stall cycles on the receiver, plus the pipeline.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 400;   // pipeline depth plus worst stall
  localparam int RANDOM_ITEMS  = 1300;
  localparam int PRINT_CAP     = 40;    // keep the log short on a broken build

  // Modulus widened so products of two residues stay exact.
  localparam logic [63:0] MOD_WIDE = {34'd0, MODULUS};
  localparam residue_t    MAX_RAW  = '1;

  typedef struct {
    residue_t value;
    residue_t inverse;
  } inv_pair_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  residue_t in_value;
  logic     out_valid;
  logic     out_stall;
  residue_t out_inverse;

  // Inverses still in flight, oldest first, with the residue that made them.
  inv_pair_t pending_inverses[$];

  int  err_cnt      = 0;
  int  sent_cnt     = 0;
  int  checked_cnt  = 0;
  int  directed_cnt = 0;
  int  unreduced_cnt = 0;
  int  cycle_cnt    = 0;

  // Idle control: when a calm flag is set that side never pauses, so the
  // pipeline also sees long runs of back-to-back transfers.
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  int  rx_wait = 0;

  always #5 clk = ~clk;

  modular_inverse_fermat uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_inverse (out_inverse)
  );

  // -------------------------------------------------------------------------
  // Expected inverse: fold an unreduced input once, then raise it to the
  // exponent MODULUS-2, scanning exponent bits from the LSB up.
  // -------------------------------------------------------------------------
  function automatic residue_t inverse_mod_p(input residue_t x);
    logic [63:0] base;
    logic [63:0] acc;
    residue_t    folded;
    folded = x;
    if (folded >= MODULUS) folded = folded - MODULUS;
    base = {34'd0, folded};
    acc  = 64'd1;
    for (int i = 0; i < EXP_BITS; i++) begin
      if (EXPONENT[i]) acc = (acc * base) % MOD_WIDE;
      base = (base * base) % MOD_WIDE;
    end
    return acc[RES_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input residue_t value,
                                 input residue_t got, input residue_t want);
    if (err_cnt < PRINT_CAP)
      $display("[%0t] MISMATCH %s: value=%0d got=%0d want=%0d",
               $realtime, what, value, got, want);
    err_cnt++;
  endtask

  // -------------------------------------------------------------------------
  // Sender: entered and left at a falling edge. An idle gap lowers valid
  // first; with no gap valid simply stays high for the next transfer, so it
  // is never dropped and raised in the same step.
  // -------------------------------------------------------------------------
  task automatic send_residue(input residue_t v);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    // transfer happens at the first rising edge with stall low
    do @(posedge clk); while (in_stall);
    pending_inverses.push_back('{value: v, inverse: inverse_mod_p(v)});
    sent_cnt++;
    @(negedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Receiver stall: after every output transfer draw how many cycles to hold
  // off the next one. Stall changes at the falling edge only.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= (rx_wait != 0);
    if (rx_wait != 0) rx_wait--;
  end

  // Result checker: each output transfer is matched against the oldest
  // pending inverse.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_inverses.size() == 0) begin
        report_mismatch("result with no pending input", '0, out_inverse, '0);
      end else begin
        inv_pair_t exp_pair;
        exp_pair = pending_inverses.pop_front();
        if (out_inverse !== exp_pair.inverse)
          report_mismatch("inverse", exp_pair.value, out_inverse, exp_pair.inverse);
        checked_cnt++;
      end
      rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) cycle_cnt++;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d inverses still pending",
             cycle_cnt, pending_inverses.size());
    $display("FAILURE");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Synchronous reset, released on a falling edge.
  task automatic apply_reset;
    rst_n <= 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
  endtask

  // Edge residues back to back at full rate: zero, one, the inverse of two,
  // the top of the range and single-bit / alternating-bit patterns.
  task automatic test_edge_residues;
    residue_t edge_vals[$];
    edge_vals = '{30'd0, 30'd1, 30'd2, 30'd3, 30'd500000004,
                  MODULUS - 30'd2, MODULUS - 30'd1,
                  30'h0000_0001 << 28, 30'h1555_5555, 30'h0AAA_AAAA,
                  30'h0FFF_FFFF, 30'h1FFF_FFFF, 30'h2000_0000, 30'd65537};
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    foreach (edge_vals[i]) send_residue(edge_vals[i]);
    directed_cnt += edge_vals.size();
  endtask

  // Values at or above the modulus: one fold, so MODULUS itself gives zero
  // and the all-ones input inverts MAX_RAW - MODULUS. Sent with idling.
  task automatic test_unreduced_inputs;
    residue_t raw_vals[$];
    raw_vals = '{MODULUS, MODULUS + 30'd1, MODULUS + 30'd2,
                 30'h3CCC_CCCC, MAX_RAW - 30'd1, MAX_RAW};
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    foreach (raw_vals[i]) send_residue(raw_vals[i]);
    directed_cnt  += raw_vals.size();
    unreduced_cnt += raw_vals.size();
  endtask

  // Bulk random residues. Most are drawn over the whole reduced range; the
  // rest hug zero, hug the modulus or lie in the unreduced band. The calm
  // flags are redrawn every 50 transfers to mix stalls with full-rate runs.
  task automatic test_random_residues;
    residue_t v;
    int       pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 9);
      if (pick < 6)
        v = residue_t'($urandom_range(0, MODULUS - 30'd1));
      else if (pick == 6)
        v = residue_t'($urandom_range(0, 1000));
      else if (pick == 7)
        v = residue_t'($urandom_range(MODULUS - 30'd1000, MODULUS - 30'd1));
      else
        v = residue_t'($urandom_range(MODULUS, MAX_RAW));
      if (v >= MODULUS) unreduced_cnt++;
      send_residue(v);
    end
  endtask

  initial begin
    in_valid  <= 1'b0;
    in_value  <= '0;
    out_stall <= 1'b0;

    apply_reset();
    test_edge_residues();
    test_unreduced_inputs();
    test_random_residues();
    in_valid <= 1'b0;

    // drain: everything sent must come back, then watch for strays
    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Inverted %0d residues (%0d directed edge values, %0d unreduced inputs),",
             sent_cnt, directed_cnt, unreduced_cnt);
    $display("checked %0d results under random idle and stall, %0d mismatches",
             checked_cnt, err_cnt);
    if (err_cnt == 0 && pending_inverses.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ modular_inverse_fermat.f @@
+incdir+hdl
hdl/mif_pkg.sv
hdl/mif_modmul.sv
hdl/mif_chain.sv
hdl/modular_inverse_fermat.sv
tb/sv/tb_modular_inverse_fermat.sv
